### design/sasq_pkg.sv
// Shared constants, codes and types for the sprite animation sequencer.
`timescale 1ns / 1ps

package sasq_pkg;

   // Sizes of the frame tables and of time and frame counts
   localparam int MAX_FRAMES = 16;
   localparam int TIME_BITS  = 32;
   localparam int FRAME_BITS = 16;

   // Field and register widths
   localparam int MODE_BITS  = 3;
   localparam int SLOT_BITS  = $clog2(MAX_FRAMES);
   localparam int DATA_BITS  = 16;
   localparam int TICK_BITS  = 16;
   localparam int LEN_BITS   = 5;
   localparam int LOOP_BITS  = 8;
   localparam int LOOP_CNT_BITS = $clog2(LOOP_BITS + 1);
   localparam int RUN_BITS   = LEN_BITS + TICK_BITS + LOOP_BITS;
   localparam int WIDE_BITS  = (RUN_BITS > TIME_BITS) ? RUN_BITS : TIME_BITS;
   localparam int ADDR_BITS  = SLOT_BITS + 1;
   localparam int RAM_DEPTH  = 2 * MAX_FRAMES;
   localparam int DIV_CNT_BITS = $clog2(TIME_BITS + 1);

   // Configuration port
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 16;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FRAME_TICKS = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LEN_A       = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LEN_B       = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LOOPS       = 2'd3;

   // Request kinds
   localparam logic [MODE_BITS-1:0] MODE_START  = 3'd0;
   localparam logic [MODE_BITS-1:0] MODE_PAUSE  = 3'd1;
   localparam logic [MODE_BITS-1:0] MODE_RESUME = 3'd2;
   localparam logic [MODE_BITS-1:0] MODE_QUERY  = 3'd3;
   localparam logic [MODE_BITS-1:0] MODE_LOAD   = 3'd4;

   // Sequencer states
   typedef enum logic [3:0] {
      S_IDLE,
      S_EXEC,
      S_RESUME,
      S_RUN,
      S_CHECK,
      S_CLAMP,
      S_DIV,
      S_READ,
      S_FINAL
   } state_type;

   // Status of the serial divider
   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

endpackage

### design/sasq_req_if.sv
// Request channel: one sequencer command with its timestamp.
`timescale 1ns / 1ps

interface sasq_req_if import sasq_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [MODE_BITS-1:0] mode;
   logic [TIME_BITS-1:0] time_now;
   logic                 track_select;
   logic [SLOT_BITS-1:0] entry_slot;
   logic [DATA_BITS-1:0] entry_data;

   modport source (output valid, mode, time_now, track_select, entry_slot, entry_data,
                   input ready);
   modport sink   (input valid, mode, time_now, track_select, entry_slot, entry_data,
                   output ready);
endinterface

### design/sasq_rsp_if.sv
// Response channel: chosen frame and animation status.
`timescale 1ns / 1ps

interface sasq_rsp_if import sasq_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [DATA_BITS-1:0]  frame_value;
   logic [FRAME_BITS-1:0] frame_number;
   logic                  finished;
   logic                  halted;
   logic                  held;

   modport source (output valid, frame_value, frame_number, finished, halted, held,
                   input ready);
   modport sink   (input valid, frame_value, frame_number, finished, halted, held,
                   output ready);
endinterface

### design/sasq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module sasq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port, then registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### design/sasq_div.sv
// Bit-serial restoring divider with a running modulo of the quotient bits.
`timescale 1ns / 1ps

module sasq_div import sasq_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [TIME_BITS-1:0]  dividend,
   input  logic [TICK_BITS-1:0]  divisor,
   input  logic [LEN_BITS-1:0]   modulus,
   output div_sts_type           sts,
   output logic [FRAME_BITS-1:0] number,
   output logic [LEN_BITS-1:0]   residue
);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [TIME_BITS-1:0]    quot_ff, quot_in;
   logic [TICK_BITS-1:0]    rem_ff, rem_in;
   logic [TICK_BITS-1:0]    dsr_ff, dsr_in;
   logic [LEN_BITS-1:0]     mod_ff, mod_in;
   logic [LEN_BITS-1:0]     len_ff, len_in;

   logic [TICK_BITS:0]      rem_shift;
   logic                    qbit;
   logic [LEN_BITS:0]       mod_shift;

   // one quotient bit per cycle; dividend leaves at the top of quot_ff,
   // quotient bits enter at the bottom
   always_comb begin
      rem_shift = {rem_ff, quot_ff[TIME_BITS-1]};
      qbit      = (rem_shift >= {1'b0, dsr_ff});
      mod_shift = {mod_ff, qbit};
      if (mod_shift >= {1'b0, len_ff}) begin
         mod_shift = mod_shift - {1'b0, len_ff};
      end

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      mod_in  = mod_ff;
      len_in  = len_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quot_in = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         mod_in  = '0;
         len_in  = modulus;
      end else if (busy_ff) begin
         quot_in = {quot_ff[TIME_BITS-2:0], qbit};
         rem_in  = qbit ? TICK_BITS'(rem_shift - {1'b0, dsr_ff})
                        : rem_shift[TICK_BITS-1:0];
         mod_in  = mod_shift[LEN_BITS-1:0];
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_BITS'(TIME_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      mod_ff  <= mod_in;
      len_ff  <= len_in;
   end

   // frame count saturates at the top of its range
   assign number   = (|quot_ff[TIME_BITS-1:FRAME_BITS]) ? {FRAME_BITS{1'b1}}
                                                         : quot_ff[FRAME_BITS-1:0];
   assign residue  = mod_ff;
   assign sts.busy = busy_ff;
   assign sts.done = done_ff;

endmodule

### design/sprite_animation_frame_sequencer.sv
// Top level of the two-track sprite animation frame sequencer.
// Start, pause, load and unused kinds go EXEC then FINAL; a resume while paused adds RESUME.
// A query runs RUN (the loop-count shift-add of the run length), CHECK, CLAMP, then DIV in the
// bit-serial divider (one quotient bit a cycle over the 32-bit elapsed time), READ and FINAL.
// The response register lets the next request be accepted while a response waits.
// Synchronous reset: stopped, not paused, times zero, registers at their defaults;
// frame tables are not cleared and hold nothing defined until loaded.
`timescale 1ns / 1ps

module sprite_animation_frame_sequencer import sasq_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   sasq_req_if.sink                 req_ch,
   sasq_rsp_if.source               rsp_ch,
   input  logic                     csr_we,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   state_type state_ff, state_in;

   // configuration
   logic [TICK_BITS-1:0] ticks_ff;
   logic [LEN_BITS-1:0]  len_a_ff, len_b_ff;
   logic [LOOP_BITS-1:0] loops_ff;

   // animation state
   logic                 halted_ff, held_ff;
   logic [TIME_BITS-1:0] start_ff, pause_ff;

   // captured request
   logic [MODE_BITS-1:0] mode_ff;
   logic [TIME_BITS-1:0] now_ff;
   logic                 sel_ff;
   logic [SLOT_BITS-1:0] slot_ff;
   logic [DATA_BITS-1:0] data_ff;

   // query working registers
   logic [TIME_BITS-1:0]     gap_ff;
   logic [TIME_BITS-1:0]     elap_ff;
   logic                     later_ff;
   logic                     fin_ff;
   logic [RUN_BITS-1:0]      mcand_ff, run_ff;
   logic [LOOP_BITS-1:0]     lc_ff;
   logic [LOOP_CNT_BITS-1:0] cnt_ff;

   // response register
   logic                  rsp_valid_ff;
   logic [DATA_BITS-1:0]  rsp_value_ff;
   logic [FRAME_BITS-1:0] rsp_number_ff;
   logic                  rsp_fin_ff;
   logic                  rsp_halted_ff;
   logic                  rsp_held_ff;

   // control strobes
   logic accept, out_free, out_load, ram_re, ram_we, div_start;

   // derived values
   logic [LEN_BITS-1:0]  len_a, len_b, len_max, len_sel, frame_idx;
   logic [TICK_BITS-1:0] tick;
   logic                 finite;
   logic [TIME_BITS-1:0] cur_time;
   logic [TIME_BITS:0]   resume_sum;
   logic [TIME_BITS-1:0] div_dividend;
   logic [ADDR_BITS-1:0] ram_raddr, ram_waddr;
   logic [DATA_BITS-1:0] ram_rdata;

   div_sts_type           div_sts;
   logic [FRAME_BITS-1:0] div_number;
   logic [LEN_BITS-1:0]   div_residue;

   // track lengths saturate at the table depth; zero frame time acts as one
   always_comb begin
      len_a     = (32'(len_a_ff) > MAX_FRAMES) ? LEN_BITS'(MAX_FRAMES) : len_a_ff;
      len_b     = (32'(len_b_ff) > MAX_FRAMES) ? LEN_BITS'(MAX_FRAMES) : len_b_ff;
      len_max   = (len_a > len_b) ? len_a : len_b;
      len_sel   = sel_ff ? len_b : len_a;
      tick      = (ticks_ff == '0) ? TICK_BITS'(1) : ticks_ff;
      finite    = (loops_ff != '0);
      cur_time  = held_ff ? pause_ff : now_ff;
      resume_sum = {1'b0, start_ff} + {1'b0, gap_ff};
      div_dividend = (finite && (WIDE_BITS'(elap_ff) > WIDE_BITS'(run_ff)))
                     ? TIME_BITS'(run_ff) : elap_ff;
      frame_idx = halted_ff ? (len_sel - 1'b1) : div_residue;
      ram_raddr = {sel_ff, frame_idx[SLOT_BITS-1:0]};
      ram_waddr = {sel_ff, slot_ff};
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (req_ch.valid) state_in = S_EXEC;
         S_EXEC: begin
            case (mode_ff)
               MODE_RESUME: state_in = held_ff ? S_RESUME : S_FINAL;
               MODE_QUERY:  state_in = S_RUN;
               default:     state_in = S_FINAL;
            endcase
         end
         S_RESUME: state_in = S_FINAL;
         S_RUN:    if (cnt_ff == LOOP_CNT_BITS'(LOOP_BITS - 1)) state_in = S_CHECK;
         S_CHECK:  state_in = S_CLAMP;
         S_CLAMP:  state_in = S_DIV;
         S_DIV:    if (div_sts.done) state_in = S_READ;
         S_READ:   state_in = S_FINAL;
         S_FINAL:  if (out_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      out_free  = !rsp_valid_ff || rsp_ch.ready;
      accept    = (state_ff == S_IDLE) && req_ch.valid;
      ram_we    = (state_ff == S_EXEC) && (mode_ff == MODE_LOAD)
                  && (32'(slot_ff) < MAX_FRAMES);
      div_start = (state_ff == S_CLAMP);
      ram_re    = (state_ff == S_READ);
      out_load  = (state_ff == S_FINAL) && out_free;
   end

   assign req_ch.ready = (state_ff == S_IDLE);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         halted_ff    <= 1'b1;
         held_ff      <= 1'b0;
         start_ff     <= '0;
         pause_ff     <= '0;
         ticks_ff     <= TICK_BITS'(1);
         len_a_ff     <= '0;
         len_b_ff     <= '0;
         loops_ff     <= '0;
      end else begin
         state_ff <= state_in;

         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         // register writes
         if (csr_we) begin
            case (csr_index)
               CSR_FRAME_TICKS: ticks_ff <= csr_wdata[TICK_BITS-1:0];
               CSR_LEN_A:       len_a_ff <= csr_wdata[LEN_BITS-1:0];
               CSR_LEN_B:       len_b_ff <= csr_wdata[LEN_BITS-1:0];
               CSR_LOOPS:       loops_ff <= csr_wdata[LOOP_BITS-1:0];
               default: ;
            endcase
         end

         // animation state updates
         case (state_ff)
            S_EXEC: begin
               case (mode_ff)
                  MODE_START: begin
                     halted_ff <= 1'b0;
                     held_ff   <= 1'b0;
                     start_ff  <= now_ff;
                     pause_ff  <= '0;
                  end
                  MODE_PAUSE: begin
                     if (!held_ff) begin
                        held_ff  <= 1'b1;
                        pause_ff <= now_ff;
                     end
                  end
                  default: ;
               endcase
            end
            S_RESUME: begin
               start_ff <= resume_sum[TIME_BITS] ? {TIME_BITS{1'b1}}
                                                 : resume_sum[TIME_BITS-1:0];
               held_ff  <= 1'b0;
               pause_ff <= '0;
            end
            S_CLAMP: begin
               if (!halted_ff && !held_ff && finite && later_ff
                   && (WIDE_BITS'(gap_ff) > WIDE_BITS'(run_ff))) begin
                  halted_ff <= 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= req_ch.mode;
         now_ff  <= req_ch.time_now;
         sel_ff  <= req_ch.track_select;
         slot_ff <= req_ch.entry_slot;
         data_ff <= req_ch.entry_data;
         fin_ff  <= 1'b0;
      end

      case (state_ff)
         S_EXEC: begin
            // pause length for a resume
            gap_ff   <= (now_ff >= pause_ff) ? (now_ff - pause_ff) : '0;
            // run length: shift-add of loop_count over the clip length
            mcand_ff <= RUN_BITS'(len_max) * RUN_BITS'(tick);
            run_ff   <= '0;
            lc_ff    <= loops_ff;
            cnt_ff   <= '0;
         end
         S_RUN: begin
            if (lc_ff[0]) begin
               run_ff <= run_ff + mcand_ff;
            end
            mcand_ff <= {mcand_ff[RUN_BITS-2:0], 1'b0};
            lc_ff    <= {1'b0, lc_ff[LOOP_BITS-1:1]};
            cnt_ff   <= cnt_ff + 1'b1;
         end
         S_CHECK: begin
            later_ff <= (now_ff > start_ff);
            gap_ff   <= now_ff - start_ff;
            elap_ff  <= (cur_time >= start_ff) ? (cur_time - start_ff) : '0;
         end
         S_CLAMP: begin
            if (!halted_ff && !held_ff && finite && later_ff
                && (WIDE_BITS'(gap_ff) > WIDE_BITS'(run_ff))) begin
               fin_ff <= 1'b1;
            end
         end
         default: ;
      endcase

      // response payload, status frozen with it while it waits
      if (out_load) begin
         if (mode_ff != MODE_QUERY || len_sel == '0) begin
            rsp_value_ff  <= '0;
            rsp_number_ff <= '0;
         end else if (halted_ff) begin
            rsp_value_ff  <= ram_rdata;
            rsp_number_ff <= FRAME_BITS'(len_sel - 1'b1);
         end else begin
            rsp_value_ff  <= ram_rdata;
            rsp_number_ff <= div_number;
         end
         rsp_fin_ff    <= fin_ff;
         rsp_halted_ff <= halted_ff;
         rsp_held_ff   <= held_ff;
      end
   end

   // both frame tables in one memory, track select as the top address bit
   sasq_ram #(
      .WIDTH (DATA_BITS),
      .DEPTH (RAM_DEPTH)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (data_ff),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // elapsed / frame time, and the quotient modulo the track length
   sasq_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (tick),
      .modulus  (len_sel),
      .sts      (div_sts),
      .number   (div_number),
      .residue  (div_residue)
   );

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.frame_value  = rsp_value_ff;
   assign rsp_ch.frame_number = rsp_number_ff;
   assign rsp_ch.finished     = rsp_fin_ff;
   assign rsp_ch.halted       = rsp_halted_ff;
   assign rsp_ch.held         = rsp_held_ff;

   // a run found over always leaves the animation stopped
   a_fin_halted: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.finished |-> rsp_ch.halted)
      else $error("finished response while not halted");

   // divider completes only while the sequencer waits on it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_sts.done |-> (state_ff == S_DIV))
      else $error("divider done outside divide state");

   // the divider is never restarted while it is working
   a_div_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_sts.busy)
      else $error("divider started while busy");

   // a response loaded from the final state is presented next cycle
   a_out_load: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_ch.valid && (state_ff == S_IDLE))
      else $error("response not presented after load");

endmodule
